FILE: hdl/asdb_pkg.sv
// Shared types, constants and the font table for the segment display buffer.
// Depends on nothing; every other file in hdl imports this package.
package asdb_pkg;

    // Sizes and defaults.
    localparam int NUM_DIGITS_DEF  = 4;
    localparam int IMAGE_BYTES_DEF = 16;
    localparam int STORE_BYTES     = 16;
    localparam int IDX_W           = 4;
    localparam int SEGS_PER_DIGIT  = 14;

    // Action codes.
    localparam logic [1:0] ACT_SET_CHAR  = 2'd0;
    localparam logic [1:0] ACT_CLEAR     = 2'd1;
    localparam logic [1:0] ACT_SET_POINT = 2'd2;
    localparam logic [1:0] ACT_FLUSH     = 2'd3;

    // Fixed bytes and positions.
    localparam logic [7:0]       REG_BYTE   = 8'h00;
    localparam logic [IDX_W-1:0] POINT_BYTE = 4'h3;
    localparam logic [6:0]       GLYPH_ALL  = 7'd95;

    // Image byte that holds each segment; segments h and i are swapped.
    localparam logic [IDX_W-1:0] SEG_BYTE [SEGS_PER_DIGIT] = '{
        4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12,
        4'd2, 4'd0, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12
    };

    // Segments h..n sit in the upper nibble of their byte.
    localparam logic [SEGS_PER_DIGIT-1:0] SEG_HI = 14'b11111110000000;

    // Font table for codes 32..127.
    localparam logic [SEGS_PER_DIGIT-1:0] FONT_ROM [96] = '{
        14'h0000, 14'h0208, 14'h0202, 14'h134E, 14'h136D, 14'h2424, 14'h0CD9, 14'h0200,
        14'h0039, 14'h000F, 14'h3E80, 14'h1340, 14'h2000, 14'h0140, 14'h0000, 14'h2400,
        14'h003F, 14'h0406, 14'h015B, 14'h014F, 14'h0166, 14'h016D, 14'h017D, 14'h1401,
        14'h017F, 14'h0167, 14'h0000, 14'h2200, 14'h0C00, 14'h0148, 14'h1080, 14'h1103,
        14'h033B, 14'h0177, 14'h130F, 14'h0039, 14'h120F, 14'h0179, 14'h0171, 14'h013D,
        14'h0176, 14'h1209, 14'h001E, 14'h0C70, 14'h0038, 14'h04B6, 14'h08B6, 14'h003F,
        14'h0173, 14'h083F, 14'h0973, 14'h018D, 14'h1201, 14'h003E, 14'h2430, 14'h2836,
        14'h2C80, 14'h1480, 14'h2409, 14'h0039, 14'h0880, 14'h000F, 14'h2800, 14'h0008,
        14'h0080, 14'h015F, 14'h0878, 14'h0158, 14'h210E, 14'h0079, 14'h0071, 14'h018F,
        14'h0174, 14'h1000, 14'h000E, 14'h1E00, 14'h1200, 14'h1154, 14'h0850, 14'h015C,
        14'h0471, 14'h0963, 14'h0050, 14'h018D, 14'h0078, 14'h001C, 14'h2010, 14'h2814,
        14'h2C80, 14'h030E, 14'h2409, 14'h20C9, 14'h1200, 14'h0D09, 14'h0152, 14'h3FFF
    };

    // Input item.
    typedef struct packed {
        logic [1:0] action;
        logic [1:0] digit;
        logic [7:0] char_code;
        logic       point_on;
    } item_t;

    // Result item.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             do_char;
        logic             do_clear;
        logic             do_point;
        logic             emit;
        logic             emit_reg;
        logic [IDX_W-1:0] emit_idx;
        logic             emit_last;
    } ctrl_cmd_t;

    // Glyph lookup; codes outside 32..127 show all segments.
    function automatic logic [SEGS_PER_DIGIT-1:0] font_glyph(input logic [7:0] code);
        logic [6:0] idx;
        if (code[7] == 1'b0 && code[6:5] != 2'b00)
        begin
            idx = code[6:0] - 7'd32;
        end
        else
        begin
            idx = GLYPH_ALL;
        end
        return FONT_ROM[idx];
    endfunction

endpackage

FILE: hdl/asdb_ctrl.sv
// Controller for the segment display buffer: accepts actions and sequences
// the flush stream. Depends on asdb_pkg.
module asdb_ctrl #(
    parameter int NUM_DIGITS  = asdb_pkg::NUM_DIGITS_DEF,
    parameter int IMAGE_BYTES = asdb_pkg::IMAGE_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           action,
    input  logic [1:0]           digit,
    output logic                 busy,
    output asdb_pkg::ctrl_cmd_t  ctrl
);
    import asdb_pkg::*;

    localparam int CNT_W = $clog2(IMAGE_BYTES + 1);

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_pos;
    logic             accept;
    logic             last_pos;

    // Item transfer and stream position.
    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign last_pos = (count_reg == CNT_W'(IMAGE_BYTES));
    assign rd_pos   = count_reg - CNT_W'(1);

    // Next state, counter and commands.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ctrl           = '0;
        ctrl.emit_idx  = rd_pos[IDX_W-1:0];
        ctrl.emit_reg  = (count_reg == '0);
        ctrl.emit_last = last_pos;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_SET_CHAR:
                        begin
                            ctrl.do_char = ({1'b0, digit} < 3'(NUM_DIGITS));
                        end
                        ACT_CLEAR:
                        begin
                            ctrl.do_clear = 1'b1;
                        end
                        ACT_SET_POINT:
                        begin
                            ctrl.do_point = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_STREAM;
                            count_next = '0;
                        end
                    endcase
                end
            end
            ST_STREAM:
            begin
                ctrl.emit  = 1'b1;
                count_next = count_reg + CNT_W'(1);
                if (last_pos)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/asdb_datapath.sv
// Datapath for the segment display buffer: the 16-byte segment image, the
// font lookup and the registered output byte. Depends on asdb_pkg.
module asdb_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  asdb_pkg::ctrl_cmd_t ctrl,
    input  logic [1:0]          digit,
    input  logic [7:0]          char_code,
    input  logic                point_on,
    output logic                result_valid,
    output asdb_pkg::result_t   result
);
    import asdb_pkg::*;

    logic [7:0]                image_reg [STORE_BYTES];
    logic [7:0]                image_next [STORE_BYTES];
    logic [SEGS_PER_DIGIT-1:0] glyph;
    logic                      valid_reg;
    result_t                   result_reg, result_next;

    assign glyph = font_glyph(char_code);

    // Image update for set-character, clear and decimal point actions.
    always_comb
    begin
        image_next = image_reg;
        if (ctrl.do_clear)
        begin
            for (int b = 0; b < STORE_BYTES; b++)
            begin
                image_next[b] = '0;
            end
        end
        if (ctrl.do_point)
        begin
            image_next[POINT_BYTE][0] = point_on;
        end
        if (ctrl.do_char)
        begin
            for (int s = 0; s < SEGS_PER_DIGIT; s++)
            begin
                image_next[SEG_BYTE[s]][{SEG_HI[s], digit}] = glyph[s];
            end
        end
    end

    // Output byte for the current stream position.
    always_comb
    begin
        result_next.frame_byte = ctrl.emit_reg ? REG_BYTE : image_reg[ctrl.emit_idx];
        result_next.frame_last = ctrl.emit_last;
    end

    // Image and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < STORE_BYTES; b++)
            begin
                image_reg[b] <= '0;
            end
            valid_reg <= 1'b0;
        end
        else
        begin
            image_reg <= image_next;
            valid_reg <= ctrl.emit;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

FILE: hdl/alnum_segment_display_buffer_core.sv
// Segment image buffer for a four-digit 14-segment display.
// Set character, clear and decimal point leave busy low, so such items may
// follow every cycle. A flush holds busy high while the stream counter steps
// through the register byte and the 16 image bytes; the first byte passes the
// state register and the output register, the rest follow each cycle without
// gaps. The receiver cannot stall. Reset clears the image to zeros and idles.
module alnum_segment_display_buffer_core #(
    parameter int NUM_DIGITS  = asdb_pkg::NUM_DIGITS_DEF,
    parameter int IMAGE_BYTES = asdb_pkg::IMAGE_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  asdb_pkg::item_t   cmd,
    output logic              result_valid,
    output asdb_pkg::result_t result
);
    import asdb_pkg::*;

    ctrl_cmd_t ctrl;

    // Action sequencing.
    asdb_ctrl #(
        .NUM_DIGITS  (NUM_DIGITS),
        .IMAGE_BYTES (IMAGE_BYTES)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (cmd.action),
        .digit  (cmd.digit),
        .busy   (busy),
        .ctrl   (ctrl)
    );

    // Segment image and output register.
    asdb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .digit        (cmd.digit),
        .char_code    (cmd.char_code),
        .point_on     (cmd.point_on),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: tb/tb_alnum_segment_display_buffer_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for alnum_segment_display_buffer_core: it drives commands
// over the start/busy handshake and checks every streamed frame byte against its
// own model of the segment image. Depends on asdb_pkg for the item types and codes.

module tb_alnum_segment_display_buffer_core;
    import asdb_pkg::*;

    // Model of the segment image, plus the frame bytes that are still owed by the block.
    class segment_image_checker;
        logic [7:0]  image_bytes [16];
        logic [13:0] font [96];
        result_t     frame_queue [$];
        int          mismatches;

        function new();
            // Glyphs for codes 32..127; the last entry lights every segment.
            font = '{
                14'h0000, 14'h0208, 14'h0202, 14'h134E, 14'h136D, 14'h2424, 14'h0CD9, 14'h0200,
                14'h0039, 14'h000F, 14'h3E80, 14'h1340, 14'h2000, 14'h0140, 14'h0000, 14'h2400,
                14'h003F, 14'h0406, 14'h015B, 14'h014F, 14'h0166, 14'h016D, 14'h017D, 14'h1401,
                14'h017F, 14'h0167, 14'h0000, 14'h2200, 14'h0C00, 14'h0148, 14'h1080, 14'h1103,
                14'h033B, 14'h0177, 14'h130F, 14'h0039, 14'h120F, 14'h0179, 14'h0171, 14'h013D,
                14'h0176, 14'h1209, 14'h001E, 14'h0C70, 14'h0038, 14'h04B6, 14'h08B6, 14'h003F,
                14'h0173, 14'h083F, 14'h0973, 14'h018D, 14'h1201, 14'h003E, 14'h2430, 14'h2836,
                14'h2C80, 14'h1480, 14'h2409, 14'h0039, 14'h0880, 14'h000F, 14'h2800, 14'h0008,
                14'h0080, 14'h015F, 14'h0878, 14'h0158, 14'h210E, 14'h0079, 14'h0071, 14'h018F,
                14'h0174, 14'h1000, 14'h000E, 14'h1E00, 14'h1200, 14'h1154, 14'h0850, 14'h015C,
                14'h0471, 14'h0963, 14'h0050, 14'h018D, 14'h0078, 14'h001C, 14'h2010, 14'h2814,
                14'h2C80, 14'h030E, 14'h2409, 14'h20C9, 14'h1200, 14'h0D09, 14'h0152, 14'h3FFF
            };
            clear_image();
            mismatches = 0;
        endfunction

        function void clear_image();
            foreach (image_bytes[i])
            begin
                image_bytes[i] = 8'h00;
            end
        endfunction

        // Apply one accepted command to the image; a flush queues the whole frame.
        function void note_command(item_t it);
            logic [13:0] glyph;
            int          com;
            int          lane;
            result_t     frame;
            case (it.action)
                ACT_SET_CHAR:
                begin
                    // Codes outside the printable range show every segment.
                    if (it.char_code >= 8'd32 && it.char_code <= 8'd127)
                    begin
                        glyph = font[it.char_code - 8'd32];
                    end
                    else
                    begin
                        glyph = font[95];
                    end
                    // Segments a..g sit in the low nibble, h..n in the high one;
                    // h and i trade bytes with each other.
                    if (int'(it.digit) < 4)
                    begin
                        for (int s = 0; s < 14; s++)
                        begin
                            lane = it.digit;
                            com  = s;
                            if (s >= 7)
                            begin
                                com  = s - 7;
                                lane = it.digit + 4;
                            end
                            if (s == 7)
                            begin
                                com = 1;
                            end
                            else if (s == 8)
                            begin
                                com = 0;
                            end
                            image_bytes[com * 2][lane] = glyph[s];
                        end
                    end
                end
                ACT_CLEAR:
                begin
                    clear_image();
                end
                ACT_SET_POINT:
                begin
                    // The decimal point is bit 0 of image byte 3.
                    image_bytes[3][0] = it.point_on;
                end
                ACT_FLUSH:
                begin
                    // Register address byte first, then the image with the last byte marked.
                    frame.frame_byte = 8'h00;
                    frame.frame_last = 1'b0;
                    frame_queue.push_back(frame);
                    for (int i = 0; i < 16; i++)
                    begin
                        frame.frame_byte = image_bytes[i];
                        frame.frame_last = (i == 15);
                        frame_queue.push_back(frame);
                    end
                end
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 40)
            begin
                $display("MISMATCH at %0t: %s", $time, what);
            end
        endtask

        // Compare one streamed byte with the oldest one owed.
        task check_frame(result_t got);
            result_t want;
            if (frame_queue.size() == 0)
            begin
                report_mismatch($sformatf("byte %02h last %b arrived with nothing owed",
                                          got.frame_byte, got.frame_last));
            end
            else
            begin
                want = frame_queue.pop_front();
                if (got.frame_byte !== want.frame_byte)
                begin
                    report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                              got.frame_byte, want.frame_byte));
                end
                if (got.frame_last !== want.frame_last)
                begin
                    report_mismatch($sformatf("frame_last %b, expected %b (byte %02h)",
                                              got.frame_last, want.frame_last,
                                              want.frame_byte));
                end
            end
        endtask

        task close();
            if (frame_queue.size() != 0)
            begin
                report_mismatch($sformatf("%0d frame bytes never arrived",
                                          frame_queue.size()));
            end
        endtask
    endclass

    localparam int WATCHDOG_LIMIT = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_ITEMS   = 350;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    item_t   cmd   = '0;
    logic    result_valid;
    result_t result;

    segment_image_checker image_model = new();
    int                   idle_cycles = 0;
    bit                   burst_mode  = 1'b0;

    alnum_segment_display_buffer_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Check each streamed byte and note each command transfer, on pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            image_model.check_frame(result);
        end
        if (rst_n && start && !busy)
        begin
            image_model.note_command(cmd);
        end
    end

    // Give up when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_alnum_segment_display_buffer_core failed");
            $finish;
        end
    end

    function automatic item_t make_item(logic [1:0] action, logic [1:0] digit,
                                         logic [7:0] code, logic point);
        item_t it;
        it.action    = action;
        it.digit     = digit;
        it.char_code = code;
        it.point_on  = point;
        return it;
    endfunction

    // Mostly character writes and flushes; codes are mostly printable.
    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        it.digit    = 2'($urandom_range(3, 0));
        it.point_on = 1'($urandom_range(1, 0));
        if ($urandom_range(9, 0) < 7)
        begin
            it.char_code = 8'($urandom_range(127, 32));
        end
        else
        begin
            it.char_code = 8'($urandom_range(255, 0));
        end
        pick = $urandom_range(99, 0);
        if (pick < 55)
        begin
            it.action = ACT_SET_CHAR;
        end
        else if (pick < 75)
        begin
            it.action = ACT_FLUSH;
        end
        else if (pick < 92)
        begin
            it.action = ACT_SET_POINT;
        end
        else
        begin
            it.action = ACT_CLEAR;
        end
        return it;
    endfunction

    // Idle for a random gap, then hold start until the block takes the command.
    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(11, 0);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: image after reset, glyphs with the swapped segments,
        // codes on both sides of the printable range, point, clear.
        send_item(make_item(ACT_FLUSH,     2'd0, 8'h00, 1'b0));
        send_item(make_item(ACT_SET_CHAR,  2'd0, 8'h41, 1'b0));
        send_item(make_item(ACT_SET_CHAR,  2'd1, 8'h2A, 1'b1));
        send_item(make_item(ACT_SET_CHAR,  2'd2, 8'h3F, 1'b0));
        send_item(make_item(ACT_SET_CHAR,  2'd3, 8'h24, 1'b1));
        send_item(make_item(ACT_SET_POINT, 2'd3, 8'hFF, 1'b1));
        send_item(make_item(ACT_FLUSH,     2'd3, 8'hFF, 1'b1));
        send_item(make_item(ACT_SET_CHAR,  2'd0, 8'h00, 1'b0));
        send_item(make_item(ACT_SET_CHAR,  2'd1, 8'h1F, 1'b0));
        send_item(make_item(ACT_SET_CHAR,  2'd2, 8'h80, 1'b1));
        send_item(make_item(ACT_SET_CHAR,  2'd3, 8'hFF, 1'b1));
        send_item(make_item(ACT_FLUSH,     2'd0, 8'h00, 1'b0));
        send_item(make_item(ACT_SET_CHAR,  2'd0, 8'h20, 1'b0));
        send_item(make_item(ACT_SET_CHAR,  2'd1, 8'h7F, 1'b0));
        send_item(make_item(ACT_SET_CHAR,  2'd3, 8'h20, 1'b1));
        send_item(make_item(ACT_SET_POINT, 2'd0, 8'h00, 1'b0));
        send_item(make_item(ACT_FLUSH,     2'd2, 8'h55, 1'b1));
        send_item(make_item(ACT_SET_CHAR,  2'd2, 8'h57, 1'b0));
        send_item(make_item(ACT_CLEAR,     2'd1, 8'hAA, 1'b1));
        send_item(make_item(ACT_FLUSH,     2'd1, 8'h00, 1'b0));
        send_item(make_item(ACT_SET_POINT, 2'd2, 8'h33, 1'b1));
        send_item(make_item(ACT_FLUSH,     2'd3, 8'hCC, 1'b0));

        // Random part; now and then a stretch with no gaps between commands.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 30 == 0)
            begin
                burst_mode = ($urandom_range(2, 0) == 0);
            end
            send_item(random_item());
        end
        start <= 1'b0;

        // Let the last frame drain, then allow a little slack for stray bytes.
        while (image_model.frame_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        image_model.close();
        if (image_model.mismatches == 0)
        begin
            $display("tb_alnum_segment_display_buffer_core passed");
        end
        else
        begin
            $display("tb_alnum_segment_display_buffer_core failed");
        end
        $finish;
    end
endmodule
